// ===== hw/rtl/rcbc_pkg.sv =====
// shared types and constants for the block cache controller
`timescale 1ns / 1ps
package rcbc_pkg;
    localparam int ENTRIES = 16;
    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [7:0] REFCOUNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        OP_ACQUIRE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_MARK    = 2'd2,
        OP_SYNC    = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_MISS      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_DONE      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        DEV_NONE  = 2'd0,
        DEV_READ  = 2'd1,
        DEV_WRITE = 2'd2
    } devop_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_QREMOVE,
        S_SYNC,
        S_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;         // capture request
        logic do_lookup;    // register tag compare
        logic qrm_start;    // start queue removal of qrm slot
        logic qrm_victim;   // remove the queue head (victim) instead of the hit slot
        logic qrm_step;     // one shift step
        logic apply;        // commit entry update for the request
        logic sync_start;
        logic sync_step;    // examine one slot
        logic out_load;     // load result register
        logic [2:0] out_status;
        logic [1:0] out_devop;
        logic out_last;
        logic out_wb;       // write-back beat of victim
        logic out_sync;     // sync write beat
    } rcbc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] opcode;
        logic hit;
        logic [7:0] hit_count;
        logic queue_empty;
        logic victim_dirty;
        logic qrm_done;
        logic sync_dirty;    // current sync slot needs write
        logic sync_at_end;   // no dirty slot past the current one
        logic sync_any;      // some write emitted in this sync
    } rcbc_stat_t;
endpackage

// ===== hw/rtl/rcbc_if.sv =====
// valid/ready channel interfaces
`timescale 1ns / 1ps
interface rcbc_req_if;
    logic valid;
    logic ready;
    logic [1:0] opcode;
    logic [15:0] block_number;
    logic set_dirty;
    modport source (output valid, opcode, block_number, set_dirty, input ready);
    modport sink (input valid, opcode, block_number, set_dirty, output ready);
endinterface

interface rcbc_rsp_if;
    logic valid;
    logic ready;
    logic [2:0] status;
    logic [3:0] slot;
    logic [1:0] device_op;
    logic [15:0] device_block;
    logic last;
    modport source (output valid, status, slot, device_op, device_block, last, input ready);
    modport sink (input valid, status, slot, device_op, device_block, last, output ready);
endinterface

// ===== hw/rtl/rcbc_datapath.sv =====
// entry arrays, reuse queue, lookup and result register
`timescale 1ns / 1ps
module rcbc_datapath
    import rcbc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       in_opcode,
    input  logic [15:0]      in_block,
    input  logic             in_set_dirty,
    input  rcbc_cmd_t        cmd,
    output rcbc_stat_t       stat,
    output logic [2:0]       out_status,
    output logic [3:0]       out_slot,
    output logic [1:0]       out_devop,
    output logic [15:0]      out_block,
    output logic             out_last
);
    logic [ENTRIES-1:0]      valid_reg;
    logic [15:0]             tag_reg [ENTRIES];
    logic [7:0]              cnt_reg [ENTRIES];
    logic [ENTRIES-1:0]      dirty_reg;
    logic [SLOT_W-1:0]       queue_reg [ENTRIES];
    logic [CNT_W-1:0]        qcount_reg;

    logic [1:0]              op_reg;
    logic [15:0]             blk_reg;
    logic                    sd_reg;
    logic                    hit_reg;
    logic [SLOT_W-1:0]       hslot_reg;
    logic [SLOT_W-1:0]       qslot_reg;   // slot being removed
    logic [SLOT_W-1:0]       qidx_reg;    // removal walk index
    logic                    qfound_reg;
    logic                    qdone_reg;
    logic [SLOT_W-1:0]       sidx_reg;
    logic                    sany_reg;

    logic                    hit_c;
    logic [SLOT_W-1:0]       hslot_c;
    logic [SLOT_W-1:0]       victim;
    logic [SLOT_W-1:0]       tgt;
    logic [ENTRIES-1:0]      later_mask;  // slots above the sync index

    always_comb
    begin
        hit_c = 1'b0;
        hslot_c = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (valid_reg[i] && tag_reg[i] == blk_reg) begin
                hit_c = 1'b1;
                hslot_c = SLOT_W'(i);
            end
        end
    end

    assign victim = queue_reg[0];
    // the queue head moves during removal, so a miss uses the captured victim
    assign tgt = hit_reg ? hslot_reg : qslot_reg;
    assign later_mask = {{(ENTRIES-1){1'b1}}, 1'b0} << sidx_reg;

    assign stat.opcode = op_reg;
    assign stat.hit = hit_reg;
    assign stat.hit_count = cnt_reg[hslot_reg];
    assign stat.queue_empty = (qcount_reg == '0);
    assign stat.victim_dirty = valid_reg[victim] && dirty_reg[victim];
    assign stat.qrm_done = qdone_reg;
    assign stat.sync_dirty = valid_reg[sidx_reg] && dirty_reg[sidx_reg];
    assign stat.sync_at_end = ((valid_reg & dirty_reg & later_mask) == '0);
    assign stat.sync_any = sany_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            op_reg <= in_opcode;
            blk_reg <= in_block;
            sd_reg <= in_set_dirty;
        end
        if (cmd.do_lookup) begin
            hit_reg <= hit_c;
            hslot_reg <= hslot_c;
        end
        if (cmd.apply) begin
            tag_reg[tgt] <= hit_reg ? tag_reg[tgt] : blk_reg;
        end
        if (cmd.out_load) begin
            out_status <= cmd.out_status;
            out_devop <= cmd.out_devop;
            out_last <= cmd.out_last;
            if (cmd.out_sync) begin
                out_slot <= 4'(sidx_reg);
                out_block <= tag_reg[sidx_reg];
            end else if (cmd.out_wb) begin
                out_slot <= 4'(victim);
                out_block <= tag_reg[victim];
            end else if (cmd.out_devop == DEV_READ) begin
                out_slot <= 4'(qslot_reg);
                out_block <= blk_reg;
            end else if (cmd.out_status == ST_HIT) begin
                out_slot <= 4'(hslot_reg);
                out_block <= '0;
            end else begin
                out_slot <= '0;
                out_block <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
            dirty_reg <= '0;
            qcount_reg <= CNT_W'(ENTRIES);
            for (int i = 0; i < ENTRIES; i++) begin
                cnt_reg[i] <= '0;
                queue_reg[i] <= SLOT_W'(i);
            end
            qslot_reg <= '0;
            qidx_reg <= '0;
            qfound_reg <= 1'b0;
            qdone_reg <= 1'b0;
            sidx_reg <= '0;
            sany_reg <= 1'b0;
        end else begin
            if (cmd.qrm_start) begin
                qslot_reg <= cmd.qrm_victim ? victim : hslot_reg;
                qidx_reg <= '0;
                qfound_reg <= 1'b0;
                qdone_reg <= 1'b0;
            end else if (cmd.qrm_step && !qdone_reg) begin
                // walk the queue; shift entries down behind the removed one
                if (CNT_W'(qidx_reg) >= qcount_reg) begin
                    qdone_reg <= 1'b1;
                    if (qfound_reg)
                        qcount_reg <= qcount_reg - 1'b1;
                end else begin
                    if (qfound_reg || queue_reg[qidx_reg] == qslot_reg) begin
                        if (CNT_W'(qidx_reg) + 1'b1 < qcount_reg)
                            queue_reg[qidx_reg] <= queue_reg[qidx_reg + 1'b1];
                        qfound_reg <= 1'b1;
                    end
                    if (qidx_reg == SLOT_W'(ENTRIES - 1)) begin
                        qdone_reg <= 1'b1;
                        if (qfound_reg || queue_reg[qidx_reg] == qslot_reg)
                            qcount_reg <= qcount_reg - 1'b1;
                    end
                    qidx_reg <= qidx_reg + 1'b1;
                end
            end
            if (cmd.apply) begin
                if (!hit_reg) begin
                    valid_reg[tgt] <= 1'b1;
                    cnt_reg[tgt] <= 8'd1;
                    dirty_reg[tgt] <= 1'b0;
                end else if (op_reg == OP_ACQUIRE) begin
                    if (cnt_reg[tgt] != REFCOUNT_MAX)
                        cnt_reg[tgt] <= cnt_reg[tgt] + 1'b1;
                end else if (op_reg == OP_RELEASE) begin
                    if (sd_reg)
                        dirty_reg[tgt] <= 1'b1;
                    if (cnt_reg[tgt] != '0) begin
                        cnt_reg[tgt] <= cnt_reg[tgt] - 1'b1;
                        if (cnt_reg[tgt] == 8'd1 && qcount_reg < CNT_W'(ENTRIES)) begin
                            queue_reg[qcount_reg[SLOT_W-1:0]] <= tgt;
                            qcount_reg <= qcount_reg + 1'b1;
                        end
                    end
                end else begin
                    if (cnt_reg[tgt] != '0)
                        dirty_reg[tgt] <= 1'b1;
                end
            end
            if (cmd.sync_start) begin
                sidx_reg <= '0;
                sany_reg <= 1'b0;
            end
            if (cmd.sync_step) begin
                if (stat.sync_dirty) begin
                    dirty_reg[sidx_reg] <= 1'b0;
                    sany_reg <= 1'b1;
                end
                sidx_reg <= sidx_reg + 1'b1;
            end
        end
    end
endmodule

// ===== hw/rtl/rcbc_ctrl.sv =====
// request sequencer for the block cache controller
`timescale 1ns / 1ps
module rcbc_ctrl
    import rcbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  rcbc_stat_t stat,
    output rcbc_cmd_t  cmd
);
    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   wb_reg, wb_next;     // read beat still owed after write-back
    logic   fin_reg, fin_next;   // last beat sent returns to idle

    logic   slot_free;
    assign slot_free = !ov_reg || out_ready;
    assign out_valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
            wb_reg <= 1'b0;
            fin_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            wb_reg <= wb_next;
            fin_reg <= fin_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ov_next = ov_reg && !out_ready;
        wb_next = wb_reg;
        fin_next = fin_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.do_lookup = 1'b1;
                cmd.sync_start = 1'b1;
                state_next = (stat.opcode == OP_SYNC) ? S_SYNC : S_DECIDE;
            end
            S_DECIDE:
            begin
                if (slot_free) begin
                    if (stat.opcode == OP_ACQUIRE && !stat.hit) begin
                        if (stat.queue_empty) begin
                            cmd.out_load = 1'b1;
                            cmd.out_status = ST_FULL;
                            cmd.out_last = 1'b1;
                            ov_next = 1'b1;
                            state_next = S_IDLE;
                        end else begin
                            cmd.qrm_start = 1'b1;
                            cmd.qrm_victim = 1'b1;
                            if (stat.victim_dirty) begin
                                cmd.out_load = 1'b1;
                                cmd.out_wb = 1'b1;
                                cmd.out_status = ST_MISS;
                                cmd.out_devop = DEV_WRITE;
                                ov_next = 1'b1;
                            end
                            wb_next = 1'b1;
                            state_next = S_QREMOVE;
                        end
                    end else if (!stat.hit) begin
                        cmd.out_load = 1'b1;
                        cmd.out_status = ST_NOT_FOUND;
                        cmd.out_last = 1'b1;
                        ov_next = 1'b1;
                        state_next = S_IDLE;
                    end else if (stat.opcode == OP_ACQUIRE && stat.hit_count == '0) begin
                        cmd.qrm_start = 1'b1;
                        wb_next = 1'b0;
                        state_next = S_QREMOVE;
                    end else begin
                        cmd.out_load = 1'b1;
                        cmd.out_status = ST_HIT;
                        cmd.out_last = 1'b1;
                        ov_next = 1'b1;
                        state_next = S_EMIT;
                    end
                end
            end
            S_QREMOVE:
            begin
                cmd.qrm_step = 1'b1;
                if (stat.qrm_done && slot_free) begin
                    cmd.qrm_step = 1'b0;
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.out_status = wb_reg ? ST_MISS : ST_HIT;
                    cmd.out_devop = wb_reg ? DEV_READ : DEV_NONE;
                    ov_next = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // commit entry update after its result beat has been loaded
                cmd.apply = 1'b1;
                state_next = S_IDLE;
            end
            S_SYNC:
            begin
                if (slot_free) begin
                    cmd.sync_step = 1'b1;
                    if (stat.sync_dirty) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sync = 1'b1;
                        cmd.out_status = ST_DONE;
                        cmd.out_devop = DEV_WRITE;
                        cmd.out_last = stat.sync_at_end;
                        ov_next = 1'b1;
                        if (stat.sync_at_end)
                            state_next = S_IDLE;
                    end else if (stat.sync_at_end) begin
                        state_next = stat.sync_any ? S_IDLE : S_EMIT;
                        fin_next = !stat.sync_any;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // sync tail: nothing was dirty, send the single empty done beat
        if (state_reg == S_EMIT && fin_reg) begin
            cmd.apply = 1'b0;
            state_next = S_EMIT;
            if (slot_free) begin
                cmd.out_load = 1'b1;
                cmd.out_status = ST_DONE;
                cmd.out_last = 1'b1;
                ov_next = 1'b1;
                fin_next = 1'b0;
                state_next = S_IDLE;
            end
        end
    end
endmodule

// ===== hw/rtl/refcounted_block_cache_controller.sv =====
// top level of the reference counted block cache controller
`timescale 1ns / 1ps
// Tag and policy controller for a 16-slot disk block cache. One request beat
// (acquire, release, mark dirty, sync) is taken at a time and answered with
// one or more result beats, the final one flagged by last. A plain request
// passes through lookup and decide (and emit on a hit) before the next
// request can be taken, and may wait on the result channel; an acquire that
// must pull a slot out of the reuse queue (a miss with a non-empty queue, and
// a hit on an unheld entry) also walks the queue. A sync steps one slot per
// cycle while the result register is free, from slot 0 up to the last dirty
// slot. Dirty victims are written back with a separate beat before the read
// beat. The result beat sits in an output register so the request side and
// the result side are decoupled; the entry update of a request is committed
// only after its final beat is loaded, while sync clears dirty bits per beat.
module refcounted_block_cache_controller
    import rcbc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    rcbc_req_if.sink   req,
    rcbc_rsp_if.source rsp
);
    rcbc_cmd_t  cmd;
    rcbc_stat_t stat;
    logic       sync_last_fix;

    // sequencer
    rcbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // entry state and result register
    rcbc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_opcode    (req.opcode),
        .in_block     (req.block_number),
        .in_set_dirty (req.set_dirty),
        .cmd          (cmd),
        .stat         (stat),
        .out_status   (rsp.status),
        .out_slot     (rsp.slot),
        .out_devop    (rsp.device_op),
        .out_block    (rsp.device_block),
        .out_last     (sync_last_fix)
    );

    assign rsp.last = sync_last_fix;
endmodule

// ===== hw/rtl/rcbc_checker.sv =====
// port-level checks for the block cache controller
`timescale 1ns / 1ps
module rcbc_port_checks
    import rcbc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  status,
    input logic [1:0]  device_op,
    input logic [15:0] device_block
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
        else $error("result dropped while stalled");
    a_noreq: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && device_op == DEV_NONE |-> device_block == 16'd0)
        else $error("block set without device op");
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_FULL |-> device_op == DEV_NONE)
        else $error("full with device op");
endmodule

bind refcounted_block_cache_controller rcbc_port_checks u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .device_op    (rsp.device_op),
    .device_block (rsp.device_block)
);
